// ===== rtl/kfq_pkg.sv =====
// Shared types and constants for the keyed FIFO queue.
// No dependencies; used by keyed_fifo_queue_unit and its testbench.

package kfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int ENTRY_W         = KEY_W + VAL_W;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_LOOK = 2'd2,
        OP_UPD  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_DEQ_RD = 2'd2,
        S_FINISH = 2'd3
    } state_t;

endpackage

// ===== rtl/kfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module kfq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/keyed_fifo_queue_unit.sv =====
// Keyed FIFO queue: a ring of key/value pairs with a unique-key scan sequencer.
// Depends on kfq_pkg and kfq_ram.
// Enqueue, lookup and update scan one held entry per cycle, stopping early on a match;
// the unit takes no new word until it has returned to idle after the result.
// Dequeue reads the head slot, or goes straight to the finish step on an empty queue; a stalled result holds it.
// Reset clears head, tail, occupancy and the handshakes; the entry RAM is not cleared.

module keyed_fifo_queue_unit #(
    parameter int QUEUE_DEPTH = kfq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      operation,
    input  logic signed [kfq_pkg::KEY_W-1:0] item_key,
    input  logic signed [kfq_pkg::VAL_W-1:0] item_value,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [2:0]                      status,
    output logic signed [kfq_pkg::KEY_W-1:0] found_key,
    output logic signed [kfq_pkg::VAL_W-1:0] found_value,
    output logic [CNT_W-1:0]                entry_count,
    output logic                            queue_empty
);

    kfq_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    kfq_pkg::op_t             op_reg, op_next;
    logic [kfq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [kfq_pkg::VAL_W-1:0] val_reg, val_next;

    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [IDX_W-1:0] iss_idx_reg, iss_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            hit_slot_reg, hit_slot_next;
    logic [kfq_pkg::ENTRY_W-1:0] hit_data_reg, hit_data_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    kfq_pkg::status_t          status_reg, status_next;
    logic [kfq_pkg::KEY_W-1:0] fkey_reg, fkey_next;
    logic [kfq_pkg::VAL_W-1:0] fval_reg, fval_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      empty_reg, empty_next;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [kfq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [kfq_pkg::ENTRY_W-1:0] ram_rdata;

    logic accept;
    logic out_free;
    logic match;
    logic scan_end;
    logic is_full;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        wrap_inc = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    kfq_ram #(
        .WIDTH(kfq_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_entry_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    // The data in flight from the RAM belongs to slot cmp_idx_reg.
    assign match    = cmp_valid_reg &&
                      (ram_rdata[kfq_pkg::ENTRY_W-1:kfq_pkg::VAL_W] == key_reg);
    assign scan_end = (iss_cnt_reg == occ_reg);
    assign is_full  = (occ_reg == CNT_W'(QUEUE_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kfq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (kfq_pkg::op_t'(operation) == kfq_pkg::OP_DEQ)
                    begin
                        state_next = (occ_reg == '0) ? kfq_pkg::S_FINISH : kfq_pkg::S_DEQ_RD;
                    end
                    else
                    begin
                        state_next = kfq_pkg::S_SCAN;
                    end
                end
            end
            kfq_pkg::S_SCAN:
            begin
                if (match || scan_end)
                begin
                    state_next = kfq_pkg::S_FINISH;
                end
            end
            kfq_pkg::S_DEQ_RD:
            begin
                state_next = kfq_pkg::S_FINISH;
            end
            kfq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = kfq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kfq_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and RAM control.
    always_comb
    begin
        req_stall = (state_reg != kfq_pkg::S_IDLE);
        ram_raddr = (state_reg == kfq_pkg::S_SCAN) ? iss_idx_reg : head_reg;
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = {key_reg, val_reg};
        if (state_reg == kfq_pkg::S_FINISH && out_free)
        begin
            case (op_reg)
                kfq_pkg::OP_ENQ:
                begin
                    ram_we = !hit_reg && !is_full;
                end
                kfq_pkg::OP_UPD:
                begin
                    ram_we    = hit_reg;
                    ram_waddr = hit_slot_reg;
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // Datapath.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_idx_next   = iss_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_data_next  = hit_data_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        fkey_next      = fkey_reg;
        fval_next      = fval_reg;
        cnt_next       = cnt_reg;
        empty_next     = empty_reg;

        case (state_reg)
            kfq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = kfq_pkg::op_t'(operation);
                    key_next       = item_key;
                    val_next       = item_value;
                    iss_cnt_next   = '0;
                    iss_idx_next   = head_reg;
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                end
            end
            kfq_pkg::S_SCAN:
            begin
                if (match)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = cmp_idx_reg;
                    hit_data_next = ram_rdata;
                end
                else if (!scan_end)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = iss_idx_reg;
                    iss_idx_next   = wrap_inc(iss_idx_reg);
                    iss_cnt_next   = iss_cnt_reg + CNT_W'(1);
                end
            end
            kfq_pkg::S_DEQ_RD:
            begin
                hit_next      = 1'b1;
                hit_data_next = ram_rdata;
            end
            kfq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = kfq_pkg::ST_OK;
                    fkey_next      = '0;
                    fval_next      = '0;
                    case (op_reg)
                        kfq_pkg::OP_ENQ:
                        begin
                            if (hit_reg)
                            begin
                                status_next = kfq_pkg::ST_DUP;
                            end
                            else if (is_full)
                            begin
                                status_next = kfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                tail_next = wrap_inc(tail_reg);
                                occ_next  = occ_reg + CNT_W'(1);
                            end
                        end
                        kfq_pkg::OP_DEQ:
                        begin
                            if (hit_reg)
                            begin
                                fkey_next = hit_data_reg[kfq_pkg::ENTRY_W-1:kfq_pkg::VAL_W];
                                fval_next = hit_data_reg[kfq_pkg::VAL_W-1:0];
                                head_next = wrap_inc(head_reg);
                                occ_next  = occ_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = kfq_pkg::ST_EMPTY;
                            end
                        end
                        kfq_pkg::OP_LOOK:
                        begin
                            if (hit_reg)
                            begin
                                fkey_next = hit_data_reg[kfq_pkg::ENTRY_W-1:kfq_pkg::VAL_W];
                                fval_next = hit_data_reg[kfq_pkg::VAL_W-1:0];
                            end
                            else
                            begin
                                status_next = kfq_pkg::ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            if (!hit_reg)
                            begin
                                status_next = kfq_pkg::ST_NOTFOUND;
                            end
                        end
                    endcase
                    cnt_next   = occ_next;
                    empty_next = (occ_next == '0);
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kfq_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            iss_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            iss_cnt_reg   <= iss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        iss_idx_reg  <= iss_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_slot_reg <= hit_slot_next;
        hit_data_reg <= hit_data_next;
        status_reg   <= status_next;
        fkey_reg     <= fkey_next;
        fval_reg     <= fval_next;
        cnt_reg      <= cnt_next;
        empty_reg    <= empty_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found_key   = fkey_reg;
    assign found_value = fval_reg;
    assign entry_count = cnt_reg;
    assign queue_empty = empty_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy exceeds the ring depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0 || occ_reg == CNT_W'(QUEUE_DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with occupancy");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == kfq_pkg::S_FINISH))
        else $error("result word raised outside the finish step");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kfq_pkg::S_SCAN) |-> iss_cnt_reg <= occ_reg)
        else $error("scan issued past the held entries");

endmodule

// ===== dv/keyed_fifo_queue_unit_test.sv =====
// Testbench for keyed_fifo_queue_unit: directed corner cases, then random traffic
// with bursts and stalls. Depends on kfq_pkg and the RTL of keyed_fifo_queue_unit;
// a ring model inside predicts each result.

module keyed_fifo_queue_unit_test;

    localparam int DEPTH        = kfq_pkg::QUEUE_DEPTH_DEF;
    localparam int COUNT_W      = $clog2(DEPTH + 1);
    localparam int RANDOM_WORDS = 2000;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    typedef struct packed {
        kfq_pkg::status_t            status;
        logic [kfq_pkg::KEY_W-1:0]   key;
        logic [kfq_pkg::VAL_W-1:0]   value;
        logic [COUNT_W-1:0]          count;
        logic                        empty;
    } queue_reply_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             req_valid = 1'b0;
    logic                             req_stall;
    logic [1:0]                       operation = kfq_pkg::OP_ENQ;
    logic signed [kfq_pkg::KEY_W-1:0] item_key = '0;
    logic signed [kfq_pkg::VAL_W-1:0] item_value = '0;
    logic                             rsp_valid;
    logic                             rsp_stall = 1'b0;
    logic [2:0]                       status;
    logic signed [kfq_pkg::KEY_W-1:0] found_key;
    logic signed [kfq_pkg::VAL_W-1:0] found_value;
    logic [COUNT_W-1:0]               entry_count;
    logic                             queue_empty;

    // Ring model of the queue contents.
    logic [kfq_pkg::KEY_W-1:0] ring_key [DEPTH];
    logic [kfq_pkg::VAL_W-1:0] ring_val [DEPTH];
    int                        ring_head = 0;
    int                        ring_tail = 0;
    int                        ring_fill = 0;

    queue_reply_t              expected_replies [$];
    logic [kfq_pkg::KEY_W-1:0] key_pool [32];
    int                        mismatch_count = 0;
    int                        burst_left = 0;
    int                        idle_cycles = 0;
    int                        stall_mode = 0;
    int                        stall_left = 0;

    keyed_fifo_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .item_key    (item_key),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found_key   (found_key),
        .found_value (found_value),
        .entry_count (entry_count),
        .queue_empty (queue_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Returns the slot of the oldest held entry with this key, or -1.
    function automatic int find_held_key(logic [kfq_pkg::KEY_W-1:0] key);
        int idx;
        for (int i = 0; i < ring_fill; i++)
        begin
            idx = (ring_head + i) % DEPTH;
            if (ring_key[idx] == key)
                return idx;
        end
        return -1;
    endfunction

    function automatic void predict_queue_word(kfq_pkg::op_t op,
                                               logic [kfq_pkg::KEY_W-1:0] key,
                                               logic [kfq_pkg::VAL_W-1:0] val);
        queue_reply_t r;
        int           slot;
        r        = '0;
        r.status = kfq_pkg::ST_OK;
        slot     = find_held_key(key);
        case (op)
            kfq_pkg::OP_ENQ:
            begin
                if (slot >= 0)
                    r.status = kfq_pkg::ST_DUP;
                else if (ring_fill >= DEPTH)
                    r.status = kfq_pkg::ST_FULL;
                else
                begin
                    ring_key[ring_tail] = key;
                    ring_val[ring_tail] = val;
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_fill++;
                end
            end
            kfq_pkg::OP_DEQ:
            begin
                if (ring_fill == 0)
                    r.status = kfq_pkg::ST_EMPTY;
                else
                begin
                    r.key   = ring_key[ring_head];
                    r.value = ring_val[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            kfq_pkg::OP_LOOK:
            begin
                if (slot < 0)
                    r.status = kfq_pkg::ST_NOTFOUND;
                else
                begin
                    r.key   = ring_key[slot];
                    r.value = ring_val[slot];
                end
            end
            default:
            begin
                if (slot < 0)
                    r.status = kfq_pkg::ST_NOTFOUND;
                else
                    ring_val[slot] = val;
            end
        endcase
        r.count = ring_fill[COUNT_W-1:0];
        r.empty = (ring_fill == 0);
        expected_replies.push_back(r);
    endfunction

    // Drives one word and returns at the edge where it is accepted; valid stays high.
    task automatic send_queue_word(input kfq_pkg::op_t op,
                                   input logic [kfq_pkg::KEY_W-1:0] key,
                                   input logic [kfq_pkg::VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_valid  <= 1'b1;
        operation  <= op;
        item_key   <= key;
        item_value <= val;
        do
            @(posedge clk);
        while (req_stall);
        predict_queue_word(op, key, val);
    endtask

    task automatic test_empty_queue();
        send_queue_word(kfq_pkg::OP_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_queue_word(kfq_pkg::OP_LOOK, 32'h8000_0000, 32'h0);
        send_queue_word(kfq_pkg::OP_UPD, 32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    // Fills the ring with extreme keys and values, then hits the full and duplicate cases.
    task automatic test_fill_to_full();
        logic [kfq_pkg::VAL_W-1:0] val;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'h0;
                3:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            send_queue_word(kfq_pkg::OP_ENQ, key_pool[i], val);
        end
        send_queue_word(kfq_pkg::OP_ENQ, key_pool[DEPTH], $urandom);
        // The duplicate check wins over the full check.
        send_queue_word(kfq_pkg::OP_ENQ, key_pool[5], $urandom);
        send_queue_word(kfq_pkg::OP_LOOK, key_pool[DEPTH - 1], $urandom);
        send_queue_word(kfq_pkg::OP_LOOK, key_pool[DEPTH + 4], $urandom);
        send_queue_word(kfq_pkg::OP_UPD, key_pool[7], $urandom);
        send_queue_word(kfq_pkg::OP_LOOK, key_pool[7], $urandom);
    endtask

    function automatic logic [kfq_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (ring_fill > 0 && r < 50)
            return ring_key[(ring_head + $urandom_range(0, ring_fill - 1)) % DEPTH];
        else if (r < 85)
            return key_pool[$urandom_range(0, 31)];
        return $urandom;
    endfunction

    // Phases lean toward filling, draining or a balance so the ring wraps and fills often.
    task automatic test_random_traffic();
        int           lean;
        int           r;
        int           enq_limit;
        int           deq_limit;
        kfq_pkg::op_t op;
        lean = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
                lean = $urandom_range(0, 2);
            enq_limit = (lean == 0) ? 60 : (lean == 1) ? 15 : 35;
            deq_limit = enq_limit + ((lean == 1) ? 55 : 30);
            r = $urandom_range(0, 99);
            if (r < enq_limit)
                op = kfq_pkg::OP_ENQ;
            else if (r < deq_limit)
                op = kfq_pkg::OP_DEQ;
            else if (r[0])
                op = kfq_pkg::OP_LOOK;
            else
                op = kfq_pkg::OP_UPD;
            send_queue_word(op, pick_key(), $urandom);
        end
    endtask

    initial
    begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 32; i++)
            key_pool[i] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_to_full();
        test_random_traffic();
        req_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && !rsp_valid)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Response checker and receiver stall pattern.
    always @(posedge clk)
    begin
        queue_reply_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result word with no expectation pending");
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    mismatch_count++;
                end
                if (found_key !== exp_r.key)
                begin
                    $error("found_key: expected %h, got %h", exp_r.key, found_key);
                    mismatch_count++;
                end
                if (found_value !== exp_r.value)
                begin
                    $error("found_value: expected %h, got %h", exp_r.value, found_value);
                    mismatch_count++;
                end
                if (entry_count !== exp_r.count)
                begin
                    $error("entry_count: expected %0d, got %0d", exp_r.count, entry_count);
                    mismatch_count++;
                end
                if (queue_empty !== exp_r.empty)
                begin
                    $error("queue_empty: expected %0d, got %0d", exp_r.empty, queue_empty);
                    mismatch_count++;
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_left[2];
        endcase
    end

    // Ends the run if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
